// File: hw/rtl/sprb_pkg.sv
// Shared types, register indexes and the helper function of the SPI response bit realigner.
package sprb_pkg;

  localparam int unsigned BYTE_WIDTH      = 8;
  localparam int unsigned CFG_INDEX_WIDTH = 2;

  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

  localparam cfg_index_t REG_IDLE_LEVEL      = 2'd0;
  localparam cfg_index_t REG_RESPONSE_LENGTH = 2'd1;

  localparam logic [BYTE_WIDTH-1:0] IDLE_BYTE_HIGH = 8'hFF;
  localparam logic [BYTE_WIDTH-1:0] IDLE_BYTE_LOW  = 8'h00;

  typedef struct packed {
    logic [BYTE_WIDTH-1:0] rx_byte;
    logic                  last_in_window;
  } in_item_t;

  typedef struct packed {
    logic                  byte_valid;
    logic [BYTE_WIDTH-1:0] aligned_byte;
    logic                  window_done;
    logic                  complete;
  } out_item_t;

  // Number of leading bits, from the MSB, that equal the idle level.
  // A byte made only of idle bits wraps to zero, as the count is three bits.
  function automatic logic [2:0] lead_count(input logic [BYTE_WIDTH-1:0] b,
                                            input logic level);
    logic [BYTE_WIDTH-1:0] v;
    logic [3:0]            n;
    logic                  run;
    v   = level ? b : ~b;
    n   = 4'd0;
    run = 1'b1;
    for (int i = BYTE_WIDTH - 1; i >= 0; i--) begin
      if (run && v[i]) begin
        n = n + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
    return n[2:0];
  endfunction

endpackage

// File: hw/rtl/sprb_align_core.sv
// Configuration registers, alignment state and the single-pass realign logic.
module sprb_align_core #(
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  sprb_pkg::cfg_index_t         cfg_index,
  input  logic [COUNT_WIDTH-1:0]       cfg_data,
  input  logic                         step,
  input  sprb_pkg::in_item_t           item,
  output sprb_pkg::out_item_t          result,
  output logic                         has_result
);

  logic                   idle_level;
  logic [COUNT_WIDTH-1:0] response_length;

  logic                   aligned;
  logic [2:0]             bit_offset;
  logic [7:0]             previous_byte;
  logic [COUNT_WIDTH-1:0] bytes_remaining;

  logic                   aligned_next;
  logic [2:0]             bit_offset_next;
  logic [7:0]             previous_byte_next;
  logic [COUNT_WIDTH-1:0] bytes_remaining_next;

  logic [7:0]             idle_byte;
  logic [15:0]            funnel;

  assign idle_byte = idle_level ? sprb_pkg::IDLE_BYTE_HIGH : sprb_pkg::IDLE_BYTE_LOW;

  // The upper half of the shifted pair is the previous byte topped up with
  // the leading bits of the current one.
  assign funnel = {previous_byte, item.rx_byte} << bit_offset;

  always_comb begin
    aligned_next         = aligned;
    bit_offset_next      = bit_offset;
    previous_byte_next   = previous_byte;
    bytes_remaining_next = bytes_remaining;
    result               = '0;

    if (step) begin
      if (!aligned) begin
        if (item.rx_byte != idle_byte) begin
          aligned_next    = 1'b1;
          bit_offset_next = sprb_pkg::lead_count(item.rx_byte, idle_level);
        end
      end else if (bytes_remaining != '0) begin
        result.byte_valid    = 1'b1;
        result.aligned_byte  = funnel[15:8];
        bytes_remaining_next = bytes_remaining - COUNT_WIDTH'(1);
      end
      previous_byte_next = item.rx_byte;

      if (item.last_in_window) begin
        result.window_done   = 1'b1;
        result.complete      = (bytes_remaining_next == '0);
        aligned_next         = 1'b0;
        bit_offset_next      = 3'd0;
        previous_byte_next   = 8'd0;
        bytes_remaining_next = response_length;
      end
    end
  end

  assign has_result = result.byte_valid || result.window_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_level      <= 1'b1;
      response_length <= COUNT_WIDTH'(1);
      aligned         <= 1'b0;
      bit_offset      <= 3'd0;
      previous_byte   <= 8'd0;
      bytes_remaining <= COUNT_WIDTH'(1);
    end else begin
      aligned         <= aligned_next;
      bit_offset      <= bit_offset_next;
      previous_byte   <= previous_byte_next;
      bytes_remaining <= bytes_remaining_next;
      if (cfg_write) begin
        case (cfg_index)
          sprb_pkg::REG_IDLE_LEVEL: begin
            idle_level <= cfg_data[0];
          end
          sprb_pkg::REG_RESPONSE_LENGTH: begin
            response_length <= cfg_data;
            // While searching, a new length applies to the current window.
            if (!aligned) begin
              bytes_remaining <= cfg_data;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: hw/rtl/spi_response_bit_realigner.sv
// Top level of the SPI response bit realigner: input register, realign core, result register.
//
// Takes one received byte per cycle and delivers realigned response bytes. An accepted
// byte is held in the input register, passes the realign logic and lands in the result
// register; the sustained rate is one byte per cycle, limited only by the result register
// being taken. Bytes that cause no result (idle bytes while searching, bytes past the
// length) leave no transfer on the output. Configuration writes are taken in any cycle
// and must be issued only while no byte is in flight.
module spi_response_bit_realigner #(
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  sprb_pkg::cfg_index_t   cfg_index,
  input  logic [COUNT_WIDTH-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sprb_pkg::in_item_t     in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sprb_pkg::out_item_t    out_data
);

  logic                s1_valid;
  sprb_pkg::in_item_t  s1_data;
  logic                advance;
  sprb_pkg::out_item_t core_result;
  logic                core_has_result;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  sprb_align_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .step       (advance),
    .item       (s1_data),
    .result     (core_result),
    .has_result (core_has_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && core_has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_has_result) begin
      out_data <= core_result;
    end
  end

endmodule

// File: hw/rtl/sprb_checker.sv
// Port-level checks of the SPI response bit realigner and their binding to the top level.
module sprb_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input sprb_pkg::out_item_t out_data
);

  // No result transfer may follow directly on a reset cycle.
  a_idle_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown in the cycle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Every transfer carries either a byte or the end of a window.
  a_no_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.byte_valid || out_data.window_done)
    else $error("result with neither byte nor window end");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_valid |-> out_data.aligned_byte == 8'd0)
    else $error("aligned byte not zero without byte_valid");

  a_complete_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.window_done |-> !out_data.complete)
    else $error("complete set outside a window end");

endmodule

bind spi_response_bit_realigner sprb_checker u_sprb_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
